@@ rtl/lru_tag_cache_macros.svh @@
// Assertion helpers shared by the RTL.
// Each macro expects a clk and an active-low rst_n in the enclosing scope.
`ifndef LRU_TAG_CACHE_MACROS_SVH
`define LRU_TAG_CACHE_MACROS_SVH

// Same-cycle implication.
`define LTC_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lru_tag_cache: same-cycle check failed");

// Next-cycle implication.
`define LTC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lru_tag_cache: next-cycle check failed");

`endif

@@ rtl/ltc_pkg.sv @@
package ltc_pkg;

  localparam int ENTRIES = 16;
  localparam int KEY_W   = 32;
  localparam int STAMP_W = 64;
  localparam int IDX_W   = $clog2(ENTRIES);
  localparam int CNT_W   = $clog2(ENTRIES + 1);
  localparam int SLOT_W  = 4;

  // Stream payload widths, rounded up to whole bytes.
  localparam int IN_BITS  = KEY_W + 1;
  localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS = 1 + SLOT_W + 1 + 1 + KEY_W;
  localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

  typedef logic [KEY_W-1:0]   key_t;
  typedef logic [STAMP_W-1:0] stamp_t;
  typedef logic [IDX_W-1:0]   idx_t;
  typedef logic [CNT_W-1:0]   cnt_t;

  // Outcome of one pass through the shared comparator.
  typedef struct packed {
    logic key_eq;  // stored key equals request key
    logic older;   // entry becomes the eviction candidate
  } cmp_res_t;

  // One result item, in tdata order from the top bit down.
  typedef struct packed {
    key_t              evicted_key;
    logic              evicted;
    logic              filled;
    logic [SLOT_W-1:0] slot;
    logic              hit;
  } out_item_t;

endpackage

@@ rtl/ltc_store.sv @@
module ltc_store
  import ltc_pkg::*;
(
  input  logic   clk,
  input  logic   wr_en,
  input  idx_t   wr_addr,
  input  key_t   wr_key,
  input  stamp_t wr_stamp,
  input  logic   rd_en,
  input  idx_t   rd_addr,
  output key_t   rd_key,
  output stamp_t rd_stamp
);

  key_t   key_mem   [ENTRIES];
  stamp_t stamp_mem [ENTRIES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      key_mem[wr_addr]   <= wr_key;
      stamp_mem[wr_addr] <= wr_stamp;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_key   <= key_mem[rd_addr];
      rd_stamp <= stamp_mem[rd_addr];
    end
  end

endmodule

@@ rtl/ltc_cmp.sv @@
module ltc_cmp
  import ltc_pkg::*;
(
  input  key_t     req_key,
  input  key_t     ent_key,
  input  stamp_t   ent_stamp,
  input  stamp_t   best_stamp,
  input  logic     first,
  output cmp_res_t res
);

  // Strict less-than keeps the lowest index on equal stamps.
  always_comb begin
    res.key_eq = (ent_key == req_key);
    res.older  = first || (ent_stamp < best_stamp);
  end

endmodule

@@ rtl/lru_tag_cache.sv @@
// Channel   Direction  tdata fields (lowest bit up)
// in_*      slave      key[31:0], fill_on_miss[32], zero pad to 40 bits
// out_*     master     hit[0], slot[4:1], filled[5], evicted[6], evicted_key[38:7], pad
//
// An empty store skips the scan, and a hit ends the scan early.
// The scan reads one entry per cycle and one shared comparator checks key
// equality and stamp age.
// rst_n clears the fill count, the use counter and the control state only.
// A stalled result holds in the output register while the next request is
// scanned; the write-back waits until that register frees up.

`include "lru_tag_cache_macros.svh"

module lru_tag_cache
  import ltc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [IN_W-1:0]  in_tdata,   // key, fill_on_miss
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [OUT_W-1:0] out_tdata   // hit, slot, filled, evicted, evicted_key
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

  state_t    state_r;
  key_t      key_r;
  logic      fill_r;
  cnt_t      occ_cnt_r;
  stamp_t    use_cnt_r;
  idx_t      issue_idx_r;
  logic      issue_more_r;
  logic      chk_vld_r;
  idx_t      chk_idx_r;
  logic      hit_r;
  idx_t      slot_r;
  idx_t      best_idx_r;
  stamp_t    best_stamp_r;
  key_t      best_key_r;
  logic      out_valid_r;
  out_item_t out_data_r;

  out_item_t res_nxt;
  logic      rd_en;
  key_t      rd_key;
  stamp_t    rd_stamp;
  logic      wr_en;
  idx_t      wr_addr;
  cmp_res_t  cmp;
  logic      last_issue;
  logic      last_chk;
  logic      out_free;
  logic      commit;
  logic      store_full;

  // ---------------------------------------------------------------------
  // Tag store and shared comparator
  // ---------------------------------------------------------------------
  ltc_store u_store (
    .clk      (clk),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_key   (key_r),
    .wr_stamp (use_cnt_r),
    .rd_en    (rd_en),
    .rd_addr  (issue_idx_r),
    .rd_key   (rd_key),
    .rd_stamp (rd_stamp)
  );

  ltc_cmp u_cmp (
    .req_key    (key_r),
    .ent_key    (rd_key),
    .ent_stamp  (rd_stamp),
    .best_stamp (best_stamp_r),
    .first      (chk_idx_r == '0),
    .res        (cmp)
  );

  // ---------------------------------------------------------------------
  // Sequencer control
  // ---------------------------------------------------------------------
  assign in_tready  = (state_r == ST_IDLE);
  assign rd_en      = (state_r == ST_SCAN) && issue_more_r;
  assign last_issue = (CNT_W'(issue_idx_r) + CNT_W'(1)) == occ_cnt_r;
  assign last_chk   = (CNT_W'(chk_idx_r) + CNT_W'(1)) == occ_cnt_r;
  assign out_free   = !out_valid_r || out_tready;
  assign commit     = (state_r == ST_FINISH) && out_free;
  assign store_full = (occ_cnt_r == CNT_W'(ENTRIES));

  // Form the result and pick the write slot: the hit entry, the next free
  // entry, or the oldest entry once the store is full.
  always_comb begin
    res_nxt = '0;
    wr_addr = '0;
    if (hit_r) begin
      res_nxt.hit  = 1'b1;
      res_nxt.slot = SLOT_W'(slot_r);
      wr_addr      = slot_r;
    end else if (fill_r) begin
      res_nxt.filled = 1'b1;
      if (store_full) begin
        res_nxt.evicted     = 1'b1;
        res_nxt.evicted_key = best_key_r;
        res_nxt.slot        = SLOT_W'(best_idx_r);
        wr_addr             = best_idx_r;
      end else begin
        res_nxt.slot = SLOT_W'(occ_cnt_r);
        wr_addr      = occ_cnt_r[IDX_W-1:0];
      end
    end
  end

  // A miss without fill writes nothing.
  assign wr_en = commit && (hit_r || fill_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      occ_cnt_r    <= '0;
      use_cnt_r    <= '0;
      issue_more_r <= 1'b0;
      chk_vld_r    <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (in_tvalid) begin
            key_r        <= in_tdata[KEY_W-1:0];
            fill_r       <= in_tdata[KEY_W];
            hit_r        <= 1'b0;
            issue_idx_r  <= '0;
            chk_vld_r    <= 1'b0;
            issue_more_r <= (occ_cnt_r != '0);
            // Skip the scan on an empty store.
            state_r      <= (occ_cnt_r == '0) ? ST_FINISH : ST_SCAN;
          end
        end
        ST_SCAN: begin
          // Issue one read per cycle; compare the entry read last cycle.
          // Reads stop with the state change on a hit.
          chk_vld_r <= rd_en;
          chk_idx_r <= issue_idx_r;
          if (rd_en) begin
            issue_idx_r <= issue_idx_r + IDX_W'(1);
            if (last_issue) begin
              issue_more_r <= 1'b0;
            end
          end
          if (chk_vld_r) begin
            if (cmp.older) begin
              best_idx_r   <= chk_idx_r;
              best_stamp_r <= rd_stamp;
              best_key_r   <= rd_key;
            end
            if (cmp.key_eq) begin
              hit_r   <= 1'b1;
              slot_r  <= chk_idx_r;
              state_r <= ST_FINISH;
            end else if (last_chk) begin
              state_r <= ST_FINISH;
            end
          end
        end
        ST_FINISH: begin
          // Hold until the output register can take the result.
          if (out_free) begin
            state_r <= ST_IDLE;
            if (!hit_r && fill_r && !store_full) begin
              occ_cnt_r <= occ_cnt_r + CNT_W'(1);
            end
            if (hit_r || fill_r) begin
              use_cnt_r <= use_cnt_r + STAMP_W'(1);
            end
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase

      // Output register: load on commit, drop after the transfer.
      if (commit) begin
        out_valid_r <= 1'b1;
        out_data_r  <= res_nxt;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_W'(out_data_r);

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  `LTC_ASSERT_IMPL(a_occ_bound, 1'b1, occ_cnt_r <= CNT_W'(ENTRIES))
  `LTC_ASSERT_NEXT(a_occ_grow, commit && res_nxt.filled && !res_nxt.evicted, occ_cnt_r == $past(occ_cnt_r) + CNT_W'(1))
  `LTC_ASSERT_IMPL(a_evict_full, out_valid_r && out_data_r.evicted, store_full)
  `LTC_ASSERT_NEXT(a_stamp_step, commit && (res_nxt.hit || res_nxt.filled), use_cnt_r == $past(use_cnt_r) + STAMP_W'(1))

endmodule

@@ test/lru_tag_cache_tb.sv @@
module lru_tag_cache_tb
  import ltc_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  // One pending request as the driver presents it. A set drain bit holds the
  // request back until every earlier lookup has produced its result.
  typedef struct {
    key_t key;
    logic fill;
    logic drain;
  } request_t;

  localparam int RANDOM_REQUESTS = 1850;
  localparam int POOL_SIZE       = 24;   // more keys than entries, so evictions recur
  localparam int LONG_HOLD       = 400;  // receiver hold-off, in cycles

  logic             clk        = 1'b0;
  logic             rst_n      = 1'b0;
  logic             in_tvalid  = 1'b0;
  logic             in_tready;
  logic [IN_W-1:0]  in_tdata   = '0;   // key, fill_on_miss
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;         // hit, slot, filled, evicted, evicted_key

  request_t  request_q[$];
  out_item_t lookup_results_due[$];

  // Shadow copy of the tag store.
  key_t              tag_key[ENTRIES];
  logic [STAMP_W-1:0] tag_stamp[ENTRIES];
  int                fill_count;
  logic [STAMP_W-1:0] stamp_counter;

  int errors;
  int n_requests, n_hits, n_fills, n_evictions, n_plain_misses, n_results;

  // Sender burst shaping.
  int burst_left;
  int gap_left;

  // Receiver stall shaping.
  int rx_count;
  int hold_left;
  int phase_left;
  int rx_mode;
  int rx_cycle;
  bit hold_a_done;
  bit hold_b_done;

  key_t key_pool[POOL_SIZE];

  lru_tag_cache u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #6 clk = ~clk;

  // Print one line per mismatch and count it.
  task automatic report_mismatch(input string msg);
    errors++;
    $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  task automatic add_request(input key_t key, input logic fill, input logic drain);
    request_t r;
    r.key   = key;
    r.fill  = fill;
    r.drain = drain;
    request_q.push_back(r);
  endtask

  // Look the key up in the shadow store, update stamps and contents the way
  // the block must, and return the result it owes for this request.
  function automatic out_item_t predict_lookup(input key_t key, input logic fill);
    out_item_t r;
    int        victim;
    r = '0;
    for (int i = 0; i < fill_count; i++) begin
      if (!r.hit && tag_key[i] == key) begin
        r.hit        = 1'b1;
        r.slot       = SLOT_W'(i);
        tag_stamp[i] = stamp_counter;
        stamp_counter++;
      end
    end
    if (!r.hit && fill) begin
      if (fill_count >= ENTRIES) begin
        // Full store: replace the least recently used entry, lowest index on a tie.
        victim = 0;
        for (int i = 1; i < ENTRIES; i++) begin
          if (tag_stamp[i] < tag_stamp[victim]) victim = i;
        end
        r.evicted     = 1'b1;
        r.evicted_key = tag_key[victim];
        n_evictions++;
      end else begin
        victim = fill_count;
        fill_count++;
      end
      tag_key[victim]   = key;
      tag_stamp[victim] = stamp_counter;
      stamp_counter++;
      r.filled = 1'b1;
      r.slot   = SLOT_W'(victim);
      n_fills++;
    end
    if (r.hit) n_hits++;
    else if (!fill) n_plain_misses++;
    n_requests++;
    return r;
  endfunction

  // Driver: on each accepted transfer, predict the result and advance to the
  // next request. Hold data while tvalid waits for tready; idle between bursts.
  always @(posedge clk) begin
    logic     accepted;
    logic     next_valid;
    request_t head;
    if (!rst_n) begin
      in_tvalid  <= 1'b0;
      burst_left <= 0;
      gap_left   <= 0;
    end else begin
      accepted = in_tvalid && in_tready;
      if (accepted) begin
        head = request_q.pop_front();
        lookup_results_due.push_back(predict_lookup(head.key, head.fill));
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          // Long bursts without gaps now and then; otherwise short ones.
          burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60)
                                                   : $urandom_range(1, 8);
          gap_left   = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 25)
                                                   : $urandom_range(0, 4);
        end
      end
      if (in_tvalid && !accepted) begin
        next_valid = 1'b1;
      end else if (gap_left > 0) begin
        gap_left--;
        next_valid = 1'b0;
      end else if (request_q.size() != 0 &&
                   !(request_q[0].drain && lookup_results_due.size() != 0)) begin
        next_valid = 1'b1;
        in_tdata   <= {{(IN_W - IN_BITS){1'b0}}, request_q[0].fill, request_q[0].key};
      end else begin
        next_valid = 1'b0;
      end
      in_tvalid <= next_valid;
    end
  end

  // Receiver: stall in a mode picked at random for each phase, and hold off for a
  // long stretch twice so the block backs up and stalls its input.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      rx_count   <= 0;
      hold_left  <= 0;
      phase_left <= 0;
      rx_mode    <= 0;
      rx_cycle   <= 0;
    end else begin
      if (out_tvalid && out_tready) rx_count++;
      rx_cycle++;
      if (phase_left == 0) begin
        phase_left = 64;
        rx_mode    = $urandom_range(0, 3);
      end
      phase_left--;
      if (!hold_a_done && rx_count >= 300) begin
        hold_a_done = 1'b1;
        hold_left   = LONG_HOLD;
      end else if (!hold_b_done && rx_count >= 1300) begin
        hold_b_done = 1'b1;
        hold_left   = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        case (rx_mode)
          0:       out_tready <= 1'b1;
          1:       out_tready <= 1'($urandom_range(0, 1));
          2:       out_tready <= ($urandom_range(0, 3) == 0);
          default: out_tready <= (rx_cycle % 3 != 0);
        endcase
      end
    end
  end

  // Monitor: compare each result transfer, field by field, with the oldest
  // prediction.
  always @(posedge clk) begin
    out_item_t got;
    out_item_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_item_t'(out_tdata[OUT_BITS-1:0]);
      if (lookup_results_due.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with nothing pending", n_results));
      end else begin
        want = lookup_results_due.pop_front();
        if (got.hit !== want.hit)
          report_mismatch($sformatf("result %0d hit %0b, want %0b",
                                    n_results, got.hit, want.hit));
        if (got.slot !== want.slot)
          report_mismatch($sformatf("result %0d slot %0d, want %0d",
                                    n_results, got.slot, want.slot));
        if (got.filled !== want.filled)
          report_mismatch($sformatf("result %0d filled %0b, want %0b",
                                    n_results, got.filled, want.filled));
        if (got.evicted !== want.evicted)
          report_mismatch($sformatf("result %0d evicted %0b, want %0b",
                                    n_results, got.evicted, want.evicted));
        if (got.evicted_key !== want.evicted_key)
          report_mismatch($sformatf("result %0d evicted_key %h, want %h",
                                    n_results, got.evicted_key, want.evicted_key));
      end
      n_results++;
    end
  end

  // Stimulus, reset and end of run.
  initial begin
    key_t key;
    logic fill;
    fill_count    = 0;
    stamp_counter = '0;

    // Directed: lookup on an empty store, the key extremes, a hit with fill
    // set, a plain miss on a partly filled store, fill to capacity, then
    // evictions after one entry was refreshed.
    add_request(32'h0000_0000, 1'b0, 1'b0);
    add_request(32'h0000_0000, 1'b1, 1'b0);
    add_request(32'hFFFF_FFFF, 1'b1, 1'b0);
    add_request(32'h0000_0000, 1'b0, 1'b0);
    add_request(32'hFFFF_FFFF, 1'b1, 1'b0);
    add_request(32'hA5A5_A5A5, 1'b0, 1'b0);
    for (int i = 2; i < ENTRIES; i++) add_request(32'h1000_0000 + i, 1'b1, 1'b0);
    add_request(32'h0000_0000, 1'b0, 1'b0);
    add_request(32'hDEAD_BEEF, 1'b1, 1'b0);
    add_request(32'h5A5A_5A5A, 1'b1, 1'b0);
    add_request(32'hFFFF_FFFF, 1'b0, 1'b0);
    add_request(32'h0000_0000, 1'b1, 1'b0);

    // Random: mostly keys from a pool slightly larger than the store, so hits,
    // fills and evictions all recur; the pool churns and fresh keys mix in.
    foreach (key_pool[i]) key_pool[i] = $urandom;
    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      if (n % 250 == 249) begin
        for (int j = 0; j < 4; j++) key_pool[$urandom_range(0, POOL_SIZE - 1)] = $urandom;
      end
      key  = ($urandom_range(0, 4) != 0) ? key_pool[$urandom_range(0, POOL_SIZE - 1)]
                                         : key_t'($urandom);
      fill = ($urandom_range(0, 3) != 0);
      // Drain the pipeline before the random part and once midway.
      add_request(key, fill, (n == 0 || n == RANDOM_REQUESTS / 2));
    end

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    while (request_q.size() != 0 || lookup_results_due.size() != 0) @(posedge clk);
    // Allow time for any stray result to show up.
    repeat (40) @(posedge clk);

    $display("Ran %0d lookups: %0d hits, %0d plain misses, %0d fills (%0d replaced an entry).",
             n_requests, n_hits, n_plain_misses, n_fills, n_evictions);
    $display("Checked %0d results; %0d field mismatches.", n_results, errors);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog: fail and stop a run that hangs.
  initial begin
    #6_000_000;
    $display("Timed out with %0d requests queued and %0d results due.",
             request_q.size(), lookup_results_due.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule
